FILE: rtl/b2da_pkg.sv
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared constants, types and helpers for the binary to decimal ASCII block.
// ----------------------------------------------------------------------------
package b2da_pkg;

  // width of the binary number, 8 to 64
  localparam int VALUE_BITS = 64;

  // fixed width of the input value field
  localparam int IN_W = 64;

  // decimal digits needed to hold 2**VALUE_BITS - 1 (log10(2) ~ 0.30103)
  localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int BCD_W  = 4 * DIGITS;
  localparam int CNT_W  = $clog2(VALUE_BITS);
  localparam int DIG_W  = $clog2(DIGITS + 1);

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // ascii '0' within the 6-bit output field
  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // one queued beat: masked value plus its class
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  is_zero;
  } item_t;

  // double-dabble correction of one bcd digit
  function automatic logic [3:0] dd_adjust(input logic [3:0] d);
    dd_adjust = (d >= 4'd5) ? (d + 4'd3) : d;
  endfunction

endpackage

FILE: rtl/b2da_front.sv
// ----------------------------------------------------------------------------
// b2da_front
// Input register: takes a beat, masks the value and marks zero values.
// ----------------------------------------------------------------------------
module b2da_front import b2da_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [IN_W-1:0] in_value,
  output logic            q_valid,
  input  logic            q_stall,
  output item_t           q_item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  accept;

  // hold off the source only while our beat cannot move on
  assign in_stall = valid_r && q_stall;
  assign accept   = in_valid && !in_stall;

  // occupancy of the input register
  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !q_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload: mask to the number width and classify
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.value   <= in_value[VALUE_BITS-1:0];
      item_r.is_zero <= (in_value[VALUE_BITS-1:0] == '0);
    end
  end

  assign q_valid = valid_r;
  assign q_item  = item_r;

endmodule

FILE: rtl/b2da_queue.sv
// ----------------------------------------------------------------------------
// b2da_queue
// Two-entry queue that decouples the front from the converter.
// ----------------------------------------------------------------------------
module b2da_queue import b2da_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_stall,
  input  item_t wr_item,
  output logic  rd_valid,
  input  logic  rd_stall,
  output item_t rd_item
);

  item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r;
  logic [Q_PTR_W-1:0] rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r;
  logic [Q_CNT_W-1:0] count_nxt;
  logic               push;
  logic               pop;

  assign wr_stall = (count_r == Q_CNT_W'(Q_DEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && !rd_stall;
  assign rd_item  = mem_r[rd_ptr_r];

  // fill level
  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

FILE: rtl/b2da_conv.sv
// ----------------------------------------------------------------------------
// b2da_conv
// Back end: shift-and-add-3 conversion, then digit emission with
// leading-zero suppression into the output register.
// ----------------------------------------------------------------------------
module b2da_conv import b2da_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_stall,
  input  item_t      q_item,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_digit_char,
  output logic       out_last_digit
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t                state_r, state_nxt;
  logic [VALUE_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [BCD_W-1:0]      bcd_adj;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DIG_W-1:0]      left_r, left_nxt;
  logic                  started_r, started_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [5:0]            char_r, char_nxt;
  logic                  last_r, last_nxt;
  logic [3:0]            top_digit;
  logic                  out_free;
  logic                  pop;

  assign q_stall   = (state_r != ST_IDLE);
  assign pop       = q_valid && !q_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  // per-digit add-3 correction, digits are independent
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[4*i +: 4] = dd_adjust(bcd_r[4*i +: 4]);
    end
  end

  // load, convert one bit a cycle, drop zeros, emit one digit a cycle if free
  always_comb begin
    state_nxt     = state_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (pop) begin
          bin_nxt     = q_item.value;
          bcd_nxt     = '0;
          cnt_nxt     = CNT_W'(VALUE_BITS - 1);
          started_nxt = 1'b0;
          if (q_item.is_zero) begin
            // zero needs no conversion: a single '0'
            left_nxt  = DIG_W'(1);
            state_nxt = ST_EMIT;
          end else begin
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[VALUE_BITS-1]};
        bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          left_nxt  = DIG_W'(DIGITS);
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!started_r && (top_digit == 4'd0) && (left_r != DIG_W'(1))) begin
          // drop a leading zero
          bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
          left_nxt = left_r - 1'b1;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = ASCII_ZERO | {2'b00, top_digit};
          last_nxt      = (left_r == DIG_W'(1));
          started_nxt   = 1'b1;
          bcd_nxt       = {bcd_r[BCD_W-5:0], 4'd0};
          left_nxt      = left_r - 1'b1;
          if (left_r == DIG_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      started_r   <= started_nxt;
    end
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    left_r <= left_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_digit_char = char_r;
  assign out_last_digit = last_r;

endmodule

FILE: rtl/binary_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Unsigned binary to decimal ASCII digits, most significant first, no
// leading zeros, one digit per output beat with a last-digit flag.
// ----------------------------------------------------------------------------
//  channel | ports                              | beat
//  --------+------------------------------------+----------------------------
//  in      | in_valid, in_stall, in_value       | one number
//  out     | out_valid, out_stall,              | one digit, 1 to 20 per
//          | out_digit_char, out_last_digit     | number
//
//  a non-zero number shifts all of its VALUE_BITS bits through the
//  shift-and-add-3 loop, then visits each digit position (DIGITS = 20 at
//  64 bits), dropping leading zeros; zero skips the loop.
//  the input register and a two-entry queue take further numbers while the
//  converter is busy, so in_stall rises only once both are full.
//  synchronous active-low reset clears all control state; no clearing pass.
//  out_stall holds the output register and pauses digit emission.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii import b2da_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [IN_W-1:0] in_value,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [5:0]      out_digit_char,
  output logic            out_last_digit
);

  logic  f_valid;
  logic  f_stall;
  item_t f_item;
  logic  q_valid;
  logic  q_stall;
  item_t q_item;

  // front: input register and classification
  b2da_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_value (in_value),
    .q_valid  (f_valid),
    .q_stall  (f_stall),
    .q_item   (f_item)
  );

  // queue between front and back
  b2da_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_stall (f_stall),
    .wr_item  (f_item),
    .rd_valid (q_valid),
    .rd_stall (q_stall),
    .rd_item  (q_item)
  );

  // back: conversion and emission
  b2da_conv u_conv (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_stall        (q_stall),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit)
  );

`ifndef SYNTHESIS
  // converter is busy right after it takes a number
  a_busy_after_pop : assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !q_stall) |=> q_stall)
    else $error("converter took a number but stayed free");

  // every digit beat carries a decimal ascii code
  a_digit_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= 6'd48) && (out_digit_char <= 6'd57))
    else $error("output digit outside '0' to '9'");

  // a zero number from the queue gives a single last '0'
  a_zero_single : assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !q_stall && q_item.is_zero && !(out_valid && out_stall))
    |=> ##1 (out_valid && out_last_digit && (out_digit_char == 6'd48)))
    else $error("zero did not give a single last '0'");
`endif

endmodule
